/* sv/histeq_pkg.sv */
// shared constants and types for the histogram equalizer
`default_nettype none
package histeq_pkg;

  // histogram geometry
  localparam int LEVELS = 256;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PIX_W  = 8;

  // image capacity and derived widths
  localparam int MAX_PIXELS = 1048576;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int NUM_W      = CNT_W + PIX_W;
  localparam int DIV_CNT_W  = $clog2(NUM_W);

  // fixed-point luma weights, sum is 65536
  localparam int GRAY_ACC_W = 24;
  localparam logic [GRAY_ACC_W-1:0] W_RED   = GRAY_ACC_W'(19595);
  localparam logic [GRAY_ACC_W-1:0] W_GREEN = GRAY_ACC_W'(38470);
  localparam logic [GRAY_ACC_W-1:0] W_BLUE  = GRAY_ACC_W'(7471);

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  typedef logic [1:0] action_t;
  localparam action_t ACT_CLEAR = 2'd0;
  localparam action_t ACT_ACCUM = 2'd1;
  localparam action_t ACT_BUILD = 2'd2;
  localparam action_t ACT_MAP   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_PHASE = 2'd2;
  localparam status_t ST_FEW   = 2'd3;

endpackage
`default_nettype wire

/* sv/histeq_if.sv */
// valid/ready channel interfaces for pixel requests and results
`default_nettype none
interface histeq_in_if;
  logic                                 valid;
  logic                                 ready;
  histeq_pkg::action_t                  action;
  logic [histeq_pkg::PIX_W-1:0]         red_in;
  logic [histeq_pkg::PIX_W-1:0]         green_in;
  logic [histeq_pkg::PIX_W-1:0]         blue_in;

  modport source (output valid, action, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface histeq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [histeq_pkg::PIX_W-1:0]         pixel_out;
  histeq_pkg::status_t                  status;

  modport source (output valid, pixel_out, status, input ready);
  modport sink   (input valid, pixel_out, status, output ready);
endinterface
`default_nettype wire

/* sv/histeq_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module histeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/histeq_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module histeq_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [histeq_pkg::NUM_W-1:0]     num,
  input  wire logic [histeq_pkg::CNT_W-1:0]     den,
  output logic                                  done,
  output logic      [histeq_pkg::NUM_W-1:0]     quot
);

  logic                                 busy_r, busy_nxt;
  logic                                 done_r, done_nxt;
  logic [histeq_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [histeq_pkg::CNT_W-1:0]         rem_r, rem_nxt;
  logic [histeq_pkg::CNT_W-1:0]         den_r, den_nxt;
  logic [histeq_pkg::NUM_W-1:0]         quot_r, quot_nxt;
  logic [histeq_pkg::CNT_W:0]           rem_sh;
  logic                                 ge;

  assign rem_sh = {rem_r, quot_r[histeq_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (busy_r) begin
      rem_nxt  = ge ? histeq_pkg::CNT_W'(rem_sh - {1'b0, den_r})
                    : rem_sh[histeq_pkg::CNT_W-1:0];
      quot_nxt = {quot_r[histeq_pkg::NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = histeq_pkg::DIV_CNT_W'(histeq_pkg::NUM_W - 1);
      rem_nxt  = '0;
      den_nxt  = den;
      quot_nxt = num;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

/* sv/histogram_equalizer.sv */
// histogram equalizer top level: gray conversion, histogram memory, cdf build and map
//
//  channel   dir   handshake          payload
//  in_ch     in    valid / ready      action, red_in, green_in, blue_in
//  out_ch    out   valid / ready      pixel_out, status
//
// one transaction at a time; a new one is taken when the sequencer is idle,
// even while the previous result still waits in the output register
// clear and rejected transactions go straight to the output state, accumulate
// does one bin read-modify-write, build writes one bin per cycle through the ram
// port, and map waits on the bit-serial divider
// reset (synchronous, active low) empties the histogram through per-bin valid
// bits at once; no clearing pass; a stalled out_ch holds the sequencer in its
// output state
`default_nettype none
module histogram_equalizer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  histeq_in_if.sink   in_ch,
  histeq_out_if.source out_ch
);

  // sequencer state codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_BUILD = 3'd3;
  localparam logic [2:0] S_MAP   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam int LEVELS = histeq_pkg::LEVELS;
  localparam int LVL_W  = histeq_pkg::LVL_W;
  localparam int CNT_W  = histeq_pkg::CNT_W;
  localparam int NUM_W  = histeq_pkg::NUM_W;
  localparam int PIX_W  = histeq_pkg::PIX_W;
  localparam int GA_W   = histeq_pkg::GRAY_ACC_W;

  logic [2:0]                 state_r, state_nxt;
  histeq_pkg::action_t        act_r, act_nxt;
  logic [LVL_W-1:0]           gray_r, gray_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       cdf_ready_r, cdf_ready_nxt;
  logic [CNT_W-1:0]           cdf0_r, cdf0_nxt;
  logic [CNT_W-1:0]           acc_r, acc_nxt;
  logic [LVL_W-1:0]           idx_r, idx_nxt;
  logic [PIX_W-1:0]           res_pix_r, res_pix_nxt;
  histeq_pkg::status_t        res_st_r, res_st_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]           out_pix_r, out_pix_nxt;
  histeq_pkg::status_t        out_st_r, out_st_nxt;
  logic [LEVELS-1:0]          vld_r, vld_nxt;
  logic                       vld_rd_r;

  logic                       in_acc;
  logic [GA_W-1:0]            gray_sum;
  logic                       ram_we;
  logic [LVL_W-1:0]           ram_waddr;
  logic [CNT_W-1:0]           ram_wdata;
  logic [LVL_W-1:0]           ram_raddr;
  logic [CNT_W-1:0]           ram_q;
  logic [CNT_W-1:0]           rd_data;
  logic [CNT_W-1:0]           diff;
  logic [NUM_W-1:0]           num;
  logic                       div_start;
  logic                       div_done;
  logic [NUM_W-1:0]           div_quot;
  logic                       clr;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // luma weights, truncated to the integer gray level
  assign gray_sum = histeq_pkg::W_RED   * GA_W'(in_ch.red_in)
                  + histeq_pkg::W_GREEN * GA_W'(in_ch.green_in)
                  + histeq_pkg::W_BLUE  * GA_W'(in_ch.blue_in);

  // bins never written since the last clear read as zero
  assign rd_data = vld_rd_r ? ram_q : '0;

  // numerator (cdf[g] - cdf[0]) * 255 as a shift and subtract
  assign diff      = rd_data - cdf0_r;
  assign num       = {diff, PIX_W'(0)} - NUM_W'(diff);
  assign div_start = (state_r == S_MAP);

  histeq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (LEVELS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  histeq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (count_r - CNT_W'(1)),
    .done  (div_done),
    .quot  (div_quot)
  );

  // read address: the gray bin, bin zero to open a build, the next bin during it
  always_comb begin
    ram_raddr = gray_r;
    if (state_r == S_DISP && act_r == histeq_pkg::ACT_BUILD) begin
      ram_raddr = '0;
    end else if (state_r == S_BUILD) begin
      ram_raddr = idx_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    gray_nxt      = gray_r;
    count_nxt     = count_r;
    cdf_ready_nxt = cdf_ready_r;
    cdf0_nxt      = cdf0_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    res_pix_nxt   = res_pix_r;
    res_st_nxt    = res_st_r;
    ram_we        = 1'b0;
    ram_waddr     = gray_r;
    ram_wdata     = rd_data + CNT_W'(1);
    clr           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt   = in_ch.action;
          gray_nxt  = gray_sum[GA_W-1 -: LVL_W];
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_pix_nxt = '0;
        res_st_nxt  = histeq_pkg::ST_OK;
        state_nxt   = S_OUT;
        unique case (act_r)
          histeq_pkg::ACT_CLEAR: begin
            clr           = 1'b1;
            count_nxt     = '0;
            cdf_ready_nxt = 1'b0;
          end
          histeq_pkg::ACT_ACCUM: begin
            res_pix_nxt = gray_r;
            if (cdf_ready_r) begin
              res_st_nxt = histeq_pkg::ST_PHASE;
            end else if (count_r >= CNT_W'(histeq_pkg::MAX_PIXELS)) begin
              res_st_nxt = histeq_pkg::ST_FULL;
            end else begin
              state_nxt = S_ACC;
            end
          end
          histeq_pkg::ACT_BUILD: begin
            if (cdf_ready_r) begin
              res_st_nxt = histeq_pkg::ST_PHASE;
            end else begin
              acc_nxt   = '0;
              idx_nxt   = '0;
              state_nxt = S_BUILD;
            end
          end
          histeq_pkg::ACT_MAP: begin
            if (!cdf_ready_r) begin
              res_st_nxt = histeq_pkg::ST_PHASE;
            end else if (count_r < CNT_W'(2)) begin
              res_st_nxt = histeq_pkg::ST_FEW;
            end else begin
              state_nxt = S_MAP;
            end
          end
          default: begin
            res_st_nxt = histeq_pkg::ST_OK;
          end
        endcase
      end
      S_ACC: begin
        // bin data arrived: increment and write back
        ram_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_OUT;
      end
      S_BUILD: begin
        // running sum, one bin per cycle
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = acc_r + rd_data;
        acc_nxt   = acc_r + rd_data;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == '0) begin
          cdf0_nxt = rd_data;
        end
        if (idx_r == LVL_W'(LEVELS - 1)) begin
          cdf_ready_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_MAP: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_pix_nxt = (|div_quot[NUM_W-1:PIX_W]) ? histeq_pkg::PIX_MAX
                                                    : div_quot[PIX_W-1:0];
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // per-bin valid bits
  always_comb begin
    vld_nxt = vld_r;
    if (clr) begin
      vld_nxt = '0;
    end else if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_st_nxt    = out_st_r;
    if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
      out_valid_nxt = 1'b1;
      out_pix_nxt   = res_pix_r;
      out_st_nxt    = res_st_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cdf_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cdf_ready_r <= cdf_ready_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
    end
    act_r     <= act_nxt;
    gray_r    <= gray_nxt;
    cdf0_r    <= cdf0_nxt;
    acc_r     <= acc_nxt;
    idx_r     <= idx_nxt;
    res_pix_r <= res_pix_nxt;
    res_st_r  <= res_st_nxt;
    out_pix_r <= out_pix_nxt;
    out_st_r  <= out_st_nxt;
    vld_rd_r  <= vld_r[ram_raddr];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_pix_r;
  assign out_ch.status    = out_st_r;

  // the histogram is only written while a transaction is in work
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("bin write while idle");

  // pixel count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(histeq_pkg::MAX_PIXELS))
    else $error("pixel count above capacity");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside map");

  // a clear leaves no cdf, an empty count and no valid bins
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP && act_r == histeq_pkg::ACT_CLEAR)
      |=> (!cdf_ready_r && count_r == '0 && vld_r == '0))
    else $error("clear left state behind");

endmodule
`default_nettype wire
